FILE: hw/rtl/encoder_setpoint_editor_unit_defines.svh
// Assertion macros for the encoder setpoint editor RTL.
// Used by encoder_setpoint_editor_unit.sv; expects signals clk and rst in scope.
`ifndef ENCODER_SETPOINT_EDITOR_UNIT_DEFINES_SVH
`define ENCODER_SETPOINT_EDITOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge outside reset.
`define ESU_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("encoder setpoint editor check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ESU_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("encoder setpoint editor check failed");

`else

`define ESU_ASSERT_IMP(name, cond, prop)
`define ESU_ASSERT_NEXT(name, cond, prop)

`endif

`endif

FILE: hw/rtl/esed_pkg.sv
// Package for the encoder setpoint editor: command codes, limits and lookup functions.
// No dependencies.
`timescale 1ns / 1ps

package esed_pkg;

  // Encoder steps that make up one detent.
  localparam int STEPS_PER_DETENT = 4;

  localparam int VALUE_W = 13;
  localparam logic [VALUE_W-1:0] MAX_VOLTAGE = 13'd6000;
  localparam logic [VALUE_W-1:0] MAX_CURRENT = 13'd2000;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_EDIT_ENABLED = 1'b0;
  localparam logic REG_CURRENT_MODE = 1'b1;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic               stepped_down;
    logic               stepped_up;
    logic [1:0]         digit_now;
    logic [VALUE_W-1:0] set_value;
  } out_item_t;

  // Quadrature transition table, indexed by {previous A, previous B, A, B}.
  function automatic logic signed [1:0] step_of(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx) inside
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
      default:                  s = 2'sd0;
    endcase
    return s;
  endfunction

  // Size of one detent move for the selected digit, in hundredths.
  function automatic logic [VALUE_W-1:0] digit_weight(input logic [1:0] pos);
    logic [VALUE_W-1:0] w;
    case (pos)
      2'd0:    w = 13'd1;
      2'd1:    w = 13'd10;
      2'd2:    w = 13'd100;
      default: w = 13'd1000;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/encoder_setpoint_editor_unit.sv
// Encoder setpoint editor: quadrature decode, detent counting and setpoint editing.
// Depends on esed_pkg and encoder_setpoint_editor_unit_defines.svh.
`timescale 1ns / 1ps
`include "encoder_setpoint_editor_unit_defines.svh"

// Channel   Direction  Signals                        Contents
// s_*       in         s_tvalid s_tready s_tdata      pins and load value, command in s_tuser
// m_*       out        m_tvalid m_tready m_tdata      setpoint, digit and detent flags
// apb       in         psel penable pwrite paddr ...  edit_enabled, current_mode
//
// Every item is finished in the cycle it is accepted: the decode, the add and the clamp
// sit between the state registers and the result register, so one item per clock while s_tready is high.
// Results pass through a two-entry output stage (result register plus skid register);
// s_tready drops only while both entries are full.
// rst is synchronous and active high; it clears the state, the registers and the
// output stage valid bits. No clearing pass is needed after reset.

module encoder_setpoint_editor_unit #(
  parameter int STEPS_PER_DETENT = esed_pkg::STEPS_PER_DETENT
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [0] pin_a, [1] pin_b, [14:2] load_value, [15] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [12:0] set_value, [14:13] digit_now,
                                 // [15] stepped_up, [16] stepped_down, [23:17] zero
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int VW = esed_pkg::VALUE_W;
  // The step count spans -STEPS_PER_DETENT .. +STEPS_PER_DETENT before it clears.
  localparam int CW = $clog2(STEPS_PER_DETENT + 1) + 1;
  localparam logic signed [CW-1:0] DETENT_POS = CW'(STEPS_PER_DETENT);
  localparam logic signed [CW-1:0] DETENT_NEG = -DETENT_POS;

  // Configuration registers.
  logic edit_enabled;
  logic current_mode;

  // Editor state.
  logic [1:0]           last_pins;
  logic signed [CW-1:0] step_count;
  logic [VW-1:0]        setpoint;
  logic [1:0]           digit_position;

  logic [1:0]           last_pins_next;
  logic signed [CW-1:0] step_count_next;
  logic [VW-1:0]        setpoint_next;
  logic [1:0]           digit_position_next;

  // Output stage: result register and skid register.
  logic                  o_valid;
  esed_pkg::out_item_t   o_item;
  logic                  k_valid;
  esed_pkg::out_item_t   k_item;
  esed_pkg::out_item_t   new_item;

  logic           in_accept;
  logic           out_pop;
  esed_pkg::cmd_t cmd;
  logic           pin_a;
  logic           pin_b;
  logic [VW-1:0]  load_value;

  logic [VW-1:0]        mode_max;
  logic [VW-1:0]        weight;
  logic [1:0]           cur_pins;
  logic signed [CW-1:0] count_sum;
  logic [VW:0]          up_sum;
  logic [VW-1:0]        down_val;
  logic [VW:0]          moved;
  logic                 up;
  logic                 down;

  // ---------------------------------------------------------------------------
  // Configuration port. A write lands in the access cycle; paddr[2] picks the
  // register and the byte offset bits are ignored.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edit_enabled <= 1'b0;
      current_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        esed_pkg::REG_EDIT_ENABLED: edit_enabled <= pwdata[0];
        esed_pkg::REG_CURRENT_MODE: current_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      esed_pkg::REG_EDIT_ENABLED: prdata = {31'b0, edit_enabled};
      esed_pkg::REG_CURRENT_MODE: prdata = {31'b0, current_mode};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshakes. A new transaction is taken unless both output entries are full.
  // ---------------------------------------------------------------------------
  assign s_tready  = !k_valid;
  assign in_accept = s_tvalid && s_tready;
  assign out_pop   = o_valid && m_tready;

  assign cmd        = esed_pkg::cmd_t'(s_tuser);
  assign pin_a      = s_tdata[0];
  assign pin_b      = s_tdata[1];
  assign load_value = s_tdata[14:2];

  // ---------------------------------------------------------------------------
  // Single-pass datapath: transition lookup, step count update, detent move
  // and clamp against the mode maximum.
  // ---------------------------------------------------------------------------
  assign mode_max  = current_mode ? esed_pkg::MAX_CURRENT : esed_pkg::MAX_VOLTAGE;
  assign weight    = esed_pkg::digit_weight(digit_position);
  assign cur_pins  = {pin_a, pin_b};
  assign count_sum = step_count + CW'(esed_pkg::step_of({last_pins, cur_pins}));
  assign up_sum    = {1'b0, setpoint} + {1'b0, weight};
  // A backward move that would go through zero stops at zero.
  assign down_val  = (setpoint > weight) ? (setpoint - weight) : '0;

  always_comb begin
    last_pins_next      = last_pins;
    step_count_next     = step_count;
    setpoint_next       = setpoint;
    digit_position_next = digit_position;
    up                  = 1'b0;
    down                = 1'b0;
    moved               = {1'b0, setpoint};

    case (cmd)
      esed_pkg::CMD_SAMPLE: begin
        // Samples leave the editor state unchanged while editing is disabled.
        if (edit_enabled) begin
          last_pins_next  = cur_pins;
          step_count_next = count_sum;
          if (count_sum >= DETENT_POS) begin
            up              = 1'b1;
            step_count_next = '0;
            moved           = up_sum;
          end else if (count_sum <= DETENT_NEG) begin
            down            = 1'b1;
            step_count_next = '0;
            moved           = {1'b0, down_val};
          end
          // A detent is flagged even when the clamp leaves the value unchanged.
          if (up || down) begin
            setpoint_next = (moved > {1'b0, mode_max}) ? mode_max : moved[VW-1:0];
          end
        end
      end
      esed_pkg::CMD_LOAD: begin
        setpoint_next = (load_value > mode_max) ? mode_max : load_value;
      end
      esed_pkg::CMD_ADVANCE: begin
        digit_position_next = digit_position + 2'd1;
      end
      default: ;
    endcase
  end

  assign new_item.set_value    = setpoint_next;
  assign new_item.digit_now    = digit_position_next;
  assign new_item.stepped_up   = up;
  assign new_item.stepped_down = down;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pins      <= 2'b11;
      step_count     <= '0;
      setpoint       <= '0;
      digit_position <= '0;
    end else if (in_accept) begin
      last_pins      <= last_pins_next;
      step_count     <= step_count_next;
      setpoint       <= setpoint_next;
      digit_position <= digit_position_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage. The skid entry only fills when the result register is held
  // by a stalled consumer, and it drains into the result register first.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      k_valid <= 1'b0;
    end else if (out_pop) begin
      if (k_valid) begin
        k_valid <= 1'b0;
      end else begin
        o_valid <= in_accept;
      end
    end else if (in_accept) begin
      if (!o_valid) begin
        o_valid <= 1'b1;
      end else begin
        k_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop) begin
      o_item <= k_valid ? k_item : new_item;
    end else if (in_accept) begin
      if (!o_valid) begin
        o_item <= new_item;
      end else begin
        k_item <= new_item;
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {7'b0, o_item};

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `ESU_ASSERT_IMP(a_skid_behind_result, k_valid, o_valid)
  `ESU_ASSERT_IMP(a_count_in_range, 1'b1,
                  (step_count < DETENT_POS) && (step_count > DETENT_NEG))
  `ESU_ASSERT_NEXT(a_non_sample_keeps_decoder, in_accept && (cmd != esed_pkg::CMD_SAMPLE),
                   $stable(step_count) && $stable(last_pins))
  `ESU_ASSERT_IMP(a_result_below_limit, o_valid,
                  (o_item.set_value <= esed_pkg::MAX_VOLTAGE) &&
                  !(o_item.stepped_up && o_item.stepped_down))

endmodule
